// ===== design/pjwh_pkg.sv =====
// Package for the PJW string hash bucket core.
// Holds widths, constants, the state encoding and the hash update function.
// No dependencies.
package pjwh_pkg;

  localparam int unsigned HashW       = 32;
  localparam int unsigned TableW      = 31;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned StepShift   = 4;
  localparam int unsigned FoldShift   = 24;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);
  localparam int unsigned DivCntW     = $clog2(HashW);

  localparam logic [HashW-1:0]  HashTopMask    = 32'hF000_0000;
  localparam logic [TableW-1:0] TableSizeReset = 31'd1024;

  localparam int unsigned RegTableSize = 0;

  typedef logic [HashW-1:0] hash_t;

  typedef enum logic [2:0] {
    BackIdle = 3'b001,
    BackDiv  = 3'b010,
    BackDone = 3'b100
  } back_state_e;

  typedef struct packed {
    logic  push;
    hash_t data;
  } queue_wr_t;

  function automatic hash_t pjw_update(hash_t h, logic [ByteW-1:0] b);
    hash_t s;
    hash_t top;
    s   = (h << StepShift) + hash_t'(b);
    top = s & HashTopMask;
    if (top != '0) begin
      s = s ^ (top >> FoldShift) ^ top;
    end
    return s;
  endfunction

endpackage

// ===== design/pjwh_front.sv =====
// Front part: takes key bytes and keeps the running PJW hash.
// Sends the finished hash to the queue on a zero byte. Uses pjwh_pkg.
module pjwh_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [pjwh_pkg::ByteW-1:0] key_byte_i,
  output pjwh_pkg::queue_wr_t      wr_o
);

  pjwh_pkg::hash_t hash_q, hash_d;

  always_comb begin
    hash_d       = hash_q;
    wr_o.push    = 1'b0;
    wr_o.data    = hash_q;
    if (accept_i) begin
      if (key_byte_i != '0) begin
        hash_d = pjwh_pkg::pjw_update(hash_q, key_byte_i);
      end else begin
        hash_d    = '0;
        wr_o.push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

// ===== design/pjwh_queue.sv =====
// Short queue of finished hashes between the front and back parts.
// Register based, depth from pjwh_pkg.
module pjwh_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pjwh_pkg::queue_wr_t wr_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output pjwh_pkg::hash_t     data_o
);

  pjwh_pkg::hash_t                       mem_q [pjwh_pkg::QueueDepth];
  logic [pjwh_pkg::QueuePtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [pjwh_pkg::QueueCntW-1:0]        cnt_q;
  logic                                  do_wr, do_rd;

  assign full_o  = (cnt_q == pjwh_pkg::QueueCntW'(pjwh_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_wr   = wr_i.push && !full_o;
  assign do_rd   = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == pjwh_pkg::QueuePtrW'(pjwh_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == pjwh_pkg::QueuePtrW'(pjwh_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/pjwh_back.sv =====
// Back part: bit-serial restoring modulo of the hash by the table size,
// one quotient bit a cycle, and the result register. Uses pjwh_pkg.
module pjwh_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  pjwh_pkg::hash_t             q_data_i,
  output logic                        q_pop_o,
  input  logic [pjwh_pkg::TableW-1:0] num_buckets_i,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [pjwh_pkg::TableW-1:0] bucket_index_o,
  output pjwh_pkg::hash_t             raw_hash_o
);

  pjwh_pkg::back_state_e              state_q, state_d;
  pjwh_pkg::hash_t                    dvd_q, dvd_d;
  pjwh_pkg::hash_t                    hash_q, hash_d;
  logic [pjwh_pkg::TableW-1:0]        rem_q, rem_d;
  logic [pjwh_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic                               res_valid_q, res_valid_d;
  logic [pjwh_pkg::TableW-1:0]        res_bucket_q, res_bucket_d;
  pjwh_pkg::hash_t                    res_hash_q, res_hash_d;
  logic [pjwh_pkg::TableW:0]          rem_sh;
  logic                               res_pop, res_free;

  assign empty_o        = !res_valid_q;
  assign bucket_index_o = res_bucket_q;
  assign raw_hash_o     = res_hash_q;
  assign res_pop        = pop_i && res_valid_q;
  assign res_free       = !res_valid_q || res_pop;
  assign rem_sh         = {rem_q, dvd_q[pjwh_pkg::HashW-1]};

  always_comb begin
    state_d      = state_q;
    dvd_d        = dvd_q;
    hash_d       = hash_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    res_valid_d  = res_valid_q && !res_pop;
    res_bucket_d = res_bucket_q;
    res_hash_d   = res_hash_q;
    q_pop_o      = 1'b0;
    case (state_q)
      pjwh_pkg::BackIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          dvd_d   = q_data_i;
          hash_d  = q_data_i;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = pjwh_pkg::BackDiv;
        end
      end
      pjwh_pkg::BackDiv: begin
        if (rem_sh >= {1'b0, num_buckets_i}) begin
          rem_d = pjwh_pkg::TableW'(rem_sh - {1'b0, num_buckets_i});
        end else begin
          rem_d = pjwh_pkg::TableW'(rem_sh);
        end
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == pjwh_pkg::DivCntW'(pjwh_pkg::HashW - 1)) begin
          state_d = pjwh_pkg::BackDone;
        end
      end
      pjwh_pkg::BackDone: begin
        if (res_free) begin
          res_valid_d  = 1'b1;
          res_bucket_d = (num_buckets_i == '0) ? '0 : rem_q;
          res_hash_d   = hash_q;
          state_d      = pjwh_pkg::BackIdle;
        end
      end
      default: begin
        state_d = pjwh_pkg::BackIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    dvd_q        <= dvd_d;
    hash_q       <= hash_d;
    rem_q        <= rem_d;
    res_bucket_q <= res_bucket_d;
    res_hash_q   <= res_hash_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pjwh_pkg::BackIdle;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule

// ===== design/pjw_string_hash_bucket_core.sv =====
// PJW string hash bucket core: front hash, result queue, back modulo, APB register.
// A terminating zero byte's hash is written to the queue, popped by the back part, put
// through the 32-step bit-serial modulo and loaded into the free result register. Key
// bytes are taken one per cycle; the back part takes a new key only once it has loaded
// the last result, and the input stalls while the two-entry queue is full.
// Reset clears the running hash, the queue and the result register; bucket count is 1024.
module pjw_string_hash_bucket_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [pjwh_pkg::ByteW-1:0]  key_byte_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [pjwh_pkg::TableW-1:0] bucket_index_o,
  output logic [pjwh_pkg::HashW-1:0]  raw_hash_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [pjwh_pkg::TableW-1:0] num_buckets_q;
  pjwh_pkg::queue_wr_t         q_wr;
  logic                        q_full, q_empty, q_pop;
  pjwh_pkg::hash_t             q_data;
  logic                        in_accept;

  assign pready    = 1'b1;
  assign prdata    = {1'b0, num_buckets_q};
  assign full      = q_full;
  assign in_accept = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_buckets_q <= pjwh_pkg::TableSizeReset;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == 2'(pjwh_pkg::RegTableSize * 4))) begin
      num_buckets_q <= pwdata[pjwh_pkg::TableW-1:0];
    end
  end

  pjwh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .key_byte_i (key_byte_i),
    .wr_o       (q_wr)
  );

  pjwh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  pjwh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .num_buckets_i  (num_buckets_q),
    .pop_i          (pop),
    .empty_o        (empty),
    .bucket_index_o (bucket_index_o),
    .raw_hash_o     (raw_hash_o)
  );

endmodule
